// File: sv/u8u2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types, constants and helpers of the UTF-8 to UCS-2 decoder.
// ----------------------------------------------------------------------------
package u8u2_pkg;

    // result queue geometry
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // code units that stand for errors and the terminator
    localparam logic [15:0] CODE_INVALID = 16'h002A;  // '*'
    localparam logic [15:0] CODE_WIDE    = 16'h007E;  // '~'
    localparam logic [15:0] CODE_TERM    = 16'h0000;

    // byte classes and masks
    localparam logic [7:0]  BYTE_ZERO    = 8'h00;
    localparam logic [7:0]  LEAD2_MASK   = 8'h1F;
    localparam logic [7:0]  LEAD3_MASK   = 8'h0F;
    localparam logic [1:0]  CONT_MARK    = 2'b10;
    localparam logic [15:0] MAX_ONE_BYTE = 16'h007F;
    localparam logic [15:0] MAX_TWO_BYTE = 16'h07FF;

    // sequence lengths given by the lead byte
    localparam logic [3:0]  LEN_ASCII    = 4'd0;
    localparam logic [3:0]  LEN_STRAY    = 4'd1;
    localparam logic [3:0]  LEN_TWO      = 4'd2;
    localparam logic [3:0]  LEN_THREE    = 4'd3;

    // how many results one byte gives
    localparam logic [1:0]  CNT_NONE     = 2'd0;
    localparam logic [1:0]  CNT_ONE      = 2'd1;
    localparam logic [1:0]  CNT_TWO      = 2'd2;

    typedef struct packed {
        logic        is_last;
        logic [15:0] code_unit;
    } result_t;

    // results of one decoded byte, first in order ahead of second
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } dec_t;

    // number of leading one bits of a byte
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       run;
        n   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

// File: sv/u8u2_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_decode
// Sequence state and per-byte decode: gives up to two results for the byte
// held in the input register and updates the state when that byte steps.
// ----------------------------------------------------------------------------
module u8u2_decode
    import u8u2_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] in_byte,
    output dec_t       dec
);

    logic [2:0]  bytes_left_reg, bytes_left_next;
    logic [3:0]  seq_length_reg, seq_length_next;
    logic [15:0] code_accum_reg, code_accum_next;
    logic        marks_ok_reg, marks_ok_next;
    logic        discarding_reg, discarding_next;

    logic [3:0]  n_ones;
    logic [15:0] accum_step;
    logic        marks_step;
    logic [2:0]  left_step;
    logic [15:0] seq_mark;
    logic [15:0] done_value;

    // continuation bytes that follow a lead byte
    function automatic logic [2:0] left_lead(input logic [3:0] n);
        logic [3:0] m;
        m = n - 4'd1;
        return m[2:0];
    endfunction

    assign n_ones     = lead_ones(in_byte);
    assign accum_step = {code_accum_reg[9:0], in_byte[5:0]};
    assign marks_step = marks_ok_reg && (in_byte[7:6] == CONT_MARK);
    assign left_step  = bytes_left_reg - 3'd1;
    assign seq_mark   = (seq_length_reg == LEN_TWO || seq_length_reg == LEN_THREE)
                        ? CODE_INVALID : CODE_WIDE;

    // value of a finished sequence, with overlong and mark checks
    always_comb begin
        if (seq_length_reg == LEN_TWO) begin
            done_value = (accum_step > MAX_ONE_BYTE && marks_step) ? accum_step
                                                                   : CODE_INVALID;
        end else if (seq_length_reg == LEN_THREE) begin
            done_value = (accum_step > MAX_TWO_BYTE && marks_step) ? accum_step
                                                                   : CODE_INVALID;
        end else begin
            done_value = CODE_WIDE;
        end
    end

    // byte decode and next state
    always_comb begin
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        code_accum_next = code_accum_reg;
        marks_ok_next   = marks_ok_reg;
        discarding_next = discarding_reg;
        dec             = '0;

        if (discarding_reg) begin
            // drop everything up to and including the next zero
            if (in_byte == BYTE_ZERO) begin
                discarding_next = 1'b0;
            end
        end else if (bytes_left_reg != 3'd0) begin
            if (in_byte == BYTE_ZERO) begin
                // zero inside a sequence: mark, then terminator
                dec.count       = CNT_TWO;
                dec.first       = '{is_last: 1'b0, code_unit: seq_mark};
                dec.second      = '{is_last: 1'b1, code_unit: CODE_TERM};
                bytes_left_next = '0;
                seq_length_next = '0;
                code_accum_next = '0;
                marks_ok_next   = 1'b1;
            end else if (left_step == 3'd0) begin
                // last byte of the sequence
                dec.count       = CNT_ONE;
                dec.first       = '{is_last: 1'b0, code_unit: done_value};
                bytes_left_next = '0;
                seq_length_next = '0;
                code_accum_next = '0;
                marks_ok_next   = 1'b1;
            end else begin
                code_accum_next = accum_step;
                marks_ok_next   = marks_step;
                bytes_left_next = left_step;
            end
        end else if (in_byte == BYTE_ZERO) begin
            dec.count = CNT_ONE;
            dec.first = '{is_last: 1'b1, code_unit: CODE_TERM};
        end else if (n_ones == LEN_ASCII) begin
            dec.count = CNT_ONE;
            dec.first = '{is_last: 1'b0, code_unit: {8'h00, in_byte}};
        end else if (n_ones == LEN_STRAY) begin
            // stray continuation byte stops the string
            dec.count       = CNT_ONE;
            dec.first       = '{is_last: 1'b1, code_unit: CODE_TERM};
            discarding_next = 1'b1;
        end else begin
            // lead byte of a multibyte sequence
            seq_length_next = n_ones;
            bytes_left_next = left_lead(n_ones);
            marks_ok_next   = 1'b1;
            if (n_ones == LEN_TWO) begin
                code_accum_next = {8'h00, in_byte & LEAD2_MASK};
            end else if (n_ones == LEN_THREE) begin
                code_accum_next = {8'h00, in_byte & LEAD3_MASK};
            end else begin
                code_accum_next = '0;
            end
        end
    end

    // sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            seq_length_reg <= '0;
            code_accum_reg <= '0;
            marks_ok_reg   <= 1'b1;
            discarding_reg <= 1'b0;
        end else if (step_en) begin
            bytes_left_reg <= bytes_left_next;
            seq_length_reg <= seq_length_next;
            code_accum_reg <= code_accum_next;
            marks_ok_reg   <= marks_ok_next;
            discarding_reg <= discarding_next;
        end
    end

    // never inside a sequence while discarding
    assert property (@(posedge aclk) disable iff (!aresetn)
        discarding_reg |-> (bytes_left_reg == 3'd0))
        else $error("discarding inside a sequence");

    // an open sequence always has a multibyte length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_left_reg != 3'd0) |-> (seq_length_reg >= LEN_TWO))
        else $error("open sequence without length");

    // two results only come from a zero inside a sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dec.count == CNT_TWO) |-> (bytes_left_reg != 3'd0 && in_byte == BYTE_ZERO
                                    && dec.second.is_last))
        else $error("unexpected second result");

endmodule

// File: sv/u8u2_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u2_fifo
// Small result queue: takes up to two results a cycle, gives one per transfer.
// ----------------------------------------------------------------------------
module u8u2_fifo
    import u8u2_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  dec_t    push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic [FIFO_AW-1:0]   wr_ptr_1;
    logic                 pop;

    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_1  = wr_ptr_reg + FIFO_AW'(1);
    assign count_next = count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);

    // storage, written only by pushes
    always_ff @(posedge aclk) begin
        if (push.count != CNT_NONE) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == CNT_TWO) begin
            entry_reg[wr_ptr_1] <= push.second;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.count);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // fill count stays within the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    // pushes only arrive when two slots are free
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != CNT_NONE) |-> room)
        else $error("push without room");

    // a lone entry taken with no push leaves the queue empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == FIFO_CW'(1) && pop && push.count == CNT_NONE) |=> !out_valid)
        else $error("queue not empty after last transfer");

endmodule

// File: sv/utf8_to_ucs2_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// Converts a UTF-8 byte stream into UCS-2 code units with a terminator flag.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                     tlast
//  s_*       in         [7:0] in_byte             -
//  m_*       out        [15:0] code_unit          is_last
//
//  One byte is taken per cycle unless the input stalls; a byte is held in
//  the input register and its results are written into the result queue.
//  Sustained rate is one result per cycle while m_tready is high, set by
//  the single output port; a zero inside a sequence gives two results.
//  A four-entry result queue decouples the sides: input stalls only when
//  fewer than two entries are free. Synchronous active-low reset clears
//  state and queue, with no clearing pass.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder
    import u8u2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // is_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       step;
    dec_t       dec;
    dec_t       push;
    result_t    out_data;

    // the held byte steps when the queue can take two results
    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;
    assign push     = step ? dec : '0;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    u8u2_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .in_byte (in_byte_reg),
        .dec     (dec)
    );

    u8u2_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data.code_unit;
    assign m_tlast = out_data.is_last;

endmodule
